>>> hw/rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define CTT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// condition must never be seen outside reset
`define CTT_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

>>> hw/rtl/ctt_pkg.sv
package ctt_pkg;

  localparam int LINE_BITS  = 16;
  localparam int LINE_OUT_W = 16;
  localparam logic [LINE_BITS-1:0] LINE_MAX = '1;

  // results one request can cause, and the queue between front and back
  localparam int RES_SLOTS = 5;
  localparam int CNT_W     = $clog2(RES_SLOTS + 1);
  localparam int Q_DEPTH   = 4;
  localparam int Q_PTR_W   = $clog2(Q_DEPTH);
  localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);

  localparam logic [7:0] CH_TAB        = 8'h09;
  localparam logic [7:0] CH_LF         = 8'h0A;
  localparam logic [7:0] CH_CR         = 8'h0D;
  localparam logic [7:0] CH_SPACE      = 8'h20;
  localparam logic [7:0] CH_QUOTE      = 8'h22;
  localparam logic [7:0] CH_HASH       = 8'h23;
  localparam logic [7:0] CH_PLUS       = 8'h2B;
  localparam logic [7:0] CH_COMMA      = 8'h2C;
  localparam logic [7:0] CH_MINUS      = 8'h2D;
  localparam logic [7:0] CH_DOT        = 8'h2E;
  localparam logic [7:0] CH_COLON      = 8'h3A;
  localparam logic [7:0] CH_LT         = 8'h3C;
  localparam logic [7:0] CH_GT         = 8'h3E;
  localparam logic [7:0] CH_UPPER_E    = 8'h45;
  localparam logic [7:0] CH_LBRACKET   = 8'h5B;
  localparam logic [7:0] CH_BSLASH     = 8'h5C;
  localparam logic [7:0] CH_RBRACKET   = 8'h5D;
  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_LOWER_E    = 8'h65;
  localparam logic [7:0] CH_LOWER_N    = 8'h6E;
  localparam logic [7:0] CH_LOWER_T    = 8'h74;
  localparam logic [7:0] CH_LBRACE     = 8'h7B;
  localparam logic [7:0] CH_RBRACE     = 8'h7D;

  typedef enum logic [3:0] {
    M_IDLE    = 4'd0,
    M_COMMENT = 4'd1,
    M_IDENT   = 4'd2,
    M_MINUS   = 4'd3,
    M_INT     = 4'd4,
    M_INTDOT  = 4'd5,
    M_FRAC    = 4'd6,
    M_EXP     = 4'd7,
    M_EXPDIG  = 4'd8,
    M_DOT     = 4'd9,
    M_STR     = 4'd10,
    M_STRESC  = 4'd11,
    M_KEY     = 4'd12,
    M_KEYESC  = 4'd13
  } mode_t;

  typedef enum logic [3:0] {
    K_IDENT    = 4'd0,
    K_INT      = 4'd1,
    K_FLOAT    = 4'd2,
    K_STRING   = 4'd3,
    K_DOTDOT   = 4'd4,
    K_COLON    = 4'd5,
    K_COMMA    = 4'd6,
    K_LBRACKET = 4'd7,
    K_RBRACKET = 4'd8,
    K_LBRACE   = 4'd9,
    K_RBRACE   = 4'd10,
    K_NEWLINE  = 4'd11,
    K_END      = 4'd12,
    K_ERROR    = 4'd13,
    K_KEYBIND  = 4'd14
  } kind_t;

  // bumped: result carries the line after this request's newline
  typedef struct packed {
    logic       is_end;
    logic [7:0] text;
    kind_t      kind;
    logic       bumped;
  } res_t;

  typedef struct packed {
    mode_t          mode;
    logic           consumed;
    logic           inc;
    logic [1:0]     n;
    res_t [2:0]     r;
  } step_t;

  typedef struct packed {
    res_t [RES_SLOTS-1:0] r;
    logic [CNT_W-1:0]     n;
  } run_t;

  typedef struct packed {
    res_t [RES_SLOTS-1:0]  res;
    logic [CNT_W-1:0]      count;
    logic [LINE_OUT_W-1:0] line_old;
    logic [LINE_OUT_W-1:0] line_new;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic is_digit(logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic res_t mk_txt(logic [7:0] b, logic bump);
    res_t r;
    r.is_end = 1'b0;
    r.text   = b;
    r.kind   = K_IDENT;
    r.bumped = bump;
    return r;
  endfunction

  function automatic res_t mk_end(kind_t k, logic bump);
    res_t r;
    r.is_end = 1'b1;
    r.text   = 8'h00;
    r.kind   = k;
    r.bumped = bump;
    return r;
  endfunction

  function automatic logic [LINE_OUT_W-1:0] line_clamp(logic [LINE_BITS-1:0] l);
    if (LINE_BITS > LINE_OUT_W && (l >> LINE_OUT_W) != '0) begin
      return '1;
    end
    return LINE_OUT_W'(l);
  endfunction

  // one pass of the scanner over a byte; not consumed means feed it again
  function automatic step_t feed(mode_t m, logic [7:0] c);
    step_t s;
    kind_t pk;
    logic  pv;
    logic  dg;
    logic  wd;
    logic  ex;
    s = '0;
    s.mode = m;
    s.consumed = 1'b1;
    dg = is_digit(c);
    wd = is_alpha(c) || dg || c == CH_UNDERSCORE;
    ex = c == CH_LOWER_E || c == CH_UPPER_E;
    pv = 1'b1;
    unique case (c)
      CH_COLON:    pk = K_COLON;
      CH_COMMA:    pk = K_COMMA;
      CH_LBRACKET: pk = K_LBRACKET;
      CH_RBRACKET: pk = K_RBRACKET;
      CH_LBRACE:   pk = K_LBRACE;
      CH_RBRACE:   pk = K_RBRACE;
      default: begin
        pk = K_ERROR;
        pv = 1'b0;
      end
    endcase
    unique case (m)
      M_IDLE: begin
        if (c == CH_SPACE || c == CH_TAB || c == CH_CR) begin
          s.n = 2'd0;
        end else if (c == CH_LF) begin
          s.inc  = 1'b1;
          s.r[0] = mk_txt(c, 1'b1);
          s.r[1] = mk_end(K_NEWLINE, 1'b1);
          s.n    = 2'd2;
        end else if (c == CH_HASH) begin
          s.mode = M_COMMENT;
        end else if (pv) begin
          s.r[0] = mk_txt(c, 1'b0);
          s.r[1] = mk_end(pk, 1'b0);
          s.n    = 2'd2;
        end else if (c == CH_LT) begin
          s.mode = M_KEY;
        end else if (c == CH_QUOTE) begin
          s.mode = M_STR;
        end else if (c == CH_DOT) begin
          s.mode = M_DOT;
        end else if (c == CH_MINUS) begin
          s.mode = M_MINUS;
        end else if (is_alpha(c) || c == CH_UNDERSCORE) begin
          s.r[0] = mk_txt(c, 1'b0);
          s.n    = 2'd1;
          s.mode = M_IDENT;
        end else if (dg) begin
          s.r[0] = mk_txt(c, 1'b0);
          s.n    = 2'd1;
          s.mode = M_INT;
        end else begin
          s.r[0] = mk_txt(c, 1'b0);
          s.r[1] = mk_end(K_ERROR, 1'b0);
          s.n    = 2'd2;
        end
      end
      M_COMMENT: begin
        if (c == CH_LF) begin
          s.mode = M_IDLE;
          s.consumed = 1'b0;
        end
      end
      M_IDENT: begin
        if (wd) begin
          s.r[0] = mk_txt(c, 1'b0);
          s.n    = 2'd1;
        end else begin
          s.r[0] = mk_end(K_IDENT, 1'b0);
          s.n    = 2'd1;
          s.mode = M_IDLE;
          s.consumed = 1'b0;
        end
      end
      M_MINUS: begin
        s.r[0] = mk_txt(CH_MINUS, 1'b0);
        s.n    = 2'd2;
        if (dg) begin
          s.r[1] = mk_txt(c, 1'b0);
          s.mode = M_INT;
        end else begin
          s.r[1] = mk_end(K_ERROR, 1'b0);
          s.mode = M_IDLE;
          s.consumed = 1'b0;
        end
      end
      M_INT: begin
        if (dg) begin
          s.r[0] = mk_txt(c, 1'b0);
          s.n    = 2'd1;
        end else if (c == CH_DOT) begin
          s.mode = M_INTDOT;
        end else if (ex) begin
          s.r[0] = mk_txt(c, 1'b0);
          s.n    = 2'd1;
          s.mode = M_EXP;
        end else begin
          s.r[0] = mk_end(K_INT, 1'b0);
          s.n    = 2'd1;
          s.mode = M_IDLE;
          s.consumed = 1'b0;
        end
      end
      M_INTDOT: begin
        if (dg) begin
          s.r[0] = mk_txt(CH_DOT, 1'b0);
          s.r[1] = mk_txt(c, 1'b0);
          s.n    = 2'd2;
          s.mode = M_FRAC;
        end else begin
          s.r[0] = mk_end(K_INT, 1'b0);
          s.n    = 2'd1;
          s.mode = M_DOT;
          s.consumed = 1'b0;
        end
      end
      M_FRAC: begin
        if (dg) begin
          s.r[0] = mk_txt(c, 1'b0);
          s.n    = 2'd1;
        end else if (ex) begin
          s.r[0] = mk_txt(c, 1'b0);
          s.n    = 2'd1;
          s.mode = M_EXP;
        end else begin
          s.r[0] = mk_end(K_FLOAT, 1'b0);
          s.n    = 2'd1;
          s.mode = M_IDLE;
          s.consumed = 1'b0;
        end
      end
      M_EXP: begin
        if (c == CH_PLUS || c == CH_MINUS || dg) begin
          s.r[0] = mk_txt(c, 1'b0);
          s.n    = 2'd1;
          s.mode = M_EXPDIG;
        end else begin
          s.r[0] = mk_end(K_FLOAT, 1'b0);
          s.n    = 2'd1;
          s.mode = M_IDLE;
          s.consumed = 1'b0;
        end
      end
      M_EXPDIG: begin
        if (dg) begin
          s.r[0] = mk_txt(c, 1'b0);
          s.n    = 2'd1;
        end else begin
          s.r[0] = mk_end(K_FLOAT, 1'b0);
          s.n    = 2'd1;
          s.mode = M_IDLE;
          s.consumed = 1'b0;
        end
      end
      M_DOT: begin
        s.mode = M_IDLE;
        s.r[0] = mk_txt(CH_DOT, 1'b0);
        if (c == CH_DOT) begin
          s.r[1] = mk_txt(CH_DOT, 1'b0);
          s.r[2] = mk_end(K_DOTDOT, 1'b0);
          s.n    = 2'd3;
        end else begin
          s.r[1] = mk_end(K_ERROR, 1'b0);
          s.n    = 2'd2;
          s.consumed = 1'b0;
        end
      end
      M_STR: begin
        if (c == CH_QUOTE) begin
          s.r[0] = mk_end(K_STRING, 1'b0);
          s.n    = 2'd1;
          s.mode = M_IDLE;
        end else if (c == CH_LF) begin
          s.r[0] = mk_end(K_STRING, 1'b0);
          s.n    = 2'd1;
          s.mode = M_IDLE;
          s.consumed = 1'b0;
        end else if (c == CH_BSLASH) begin
          s.mode = M_STRESC;
        end else begin
          s.r[0] = mk_txt(c, 1'b0);
          s.n    = 2'd1;
        end
      end
      M_STRESC: begin
        s.mode = M_STR;
        s.n    = 2'd1;
        if (c == CH_LOWER_N) begin
          s.r[0] = mk_txt(CH_LF, 1'b0);
        end else if (c == CH_LOWER_T) begin
          s.r[0] = mk_txt(CH_TAB, 1'b0);
        end else if (c == CH_QUOTE || c == CH_BSLASH) begin
          s.r[0] = mk_txt(c, 1'b0);
        end else begin
          s.r[0] = mk_txt(CH_BSLASH, 1'b0);
          s.r[1] = mk_txt(c, 1'b0);
          s.n    = 2'd2;
        end
      end
      M_KEY: begin
        if (c == CH_GT) begin
          s.r[0] = mk_end(K_KEYBIND, 1'b0);
          s.n    = 2'd1;
          s.mode = M_IDLE;
        end else if (c == CH_LF) begin
          s.r[0] = mk_end(K_KEYBIND, 1'b0);
          s.n    = 2'd1;
          s.mode = M_IDLE;
          s.consumed = 1'b0;
        end else if (c == CH_BSLASH) begin
          s.mode = M_KEYESC;
        end else begin
          s.r[0] = mk_txt(c, 1'b0);
          s.n    = 2'd1;
        end
      end
      M_KEYESC: begin
        s.r[0] = mk_txt(CH_BSLASH, 1'b0);
        s.r[1] = mk_txt(c, 1'b0);
        s.n    = 2'd2;
        s.mode = M_KEY;
      end
      default: begin
        s.mode = M_IDLE;
        s.consumed = 1'b0;
      end
    endcase
    return s;
  endfunction

  // close whatever token is open, then End
  function automatic run_t flush(mode_t m);
    run_t f;
    f = '0;
    unique case (m) inside
      M_IDENT: begin
        f.r[0] = mk_end(K_IDENT, 1'b0);
        f.n    = CNT_W'(1);
      end
      M_MINUS: begin
        f.r[0] = mk_txt(CH_MINUS, 1'b0);
        f.r[1] = mk_end(K_ERROR, 1'b0);
        f.n    = CNT_W'(2);
      end
      M_INT: begin
        f.r[0] = mk_end(K_INT, 1'b0);
        f.n    = CNT_W'(1);
      end
      M_INTDOT: begin
        f.r[0] = mk_end(K_INT, 1'b0);
        f.r[1] = mk_txt(CH_DOT, 1'b0);
        f.r[2] = mk_end(K_ERROR, 1'b0);
        f.n    = CNT_W'(3);
      end
      M_FRAC, M_EXP, M_EXPDIG: begin
        f.r[0] = mk_end(K_FLOAT, 1'b0);
        f.n    = CNT_W'(1);
      end
      M_DOT: begin
        f.r[0] = mk_txt(CH_DOT, 1'b0);
        f.r[1] = mk_end(K_ERROR, 1'b0);
        f.n    = CNT_W'(2);
      end
      M_STR: begin
        f.r[0] = mk_end(K_STRING, 1'b0);
        f.n    = CNT_W'(1);
      end
      M_STRESC: begin
        f.r[0] = mk_txt(CH_BSLASH, 1'b0);
        f.r[1] = mk_end(K_STRING, 1'b0);
        f.n    = CNT_W'(2);
      end
      M_KEY: begin
        f.r[0] = mk_end(K_KEYBIND, 1'b0);
        f.n    = CNT_W'(1);
      end
      M_KEYESC: begin
        f.r[0] = mk_txt(CH_BSLASH, 1'b0);
        f.r[1] = mk_end(K_KEYBIND, 1'b0);
        f.n    = CNT_W'(2);
      end
      default: begin
        f.n = '0;
      end
    endcase
    f.r[f.n] = mk_end(K_END, 1'b0);
    f.n = f.n + 1'b1;
    return f;
  endfunction

endpackage

>>> hw/rtl/ctt_in_if.sv
interface ctt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] source_byte;
  logic       end_marker;

  modport source (output valid, output source_byte, output end_marker, input ready);
  modport sink (input valid, input source_byte, input end_marker, output ready);
endinterface

>>> hw/rtl/ctt_out_if.sv
interface ctt_out_if;
  logic        valid;
  logic        ready;
  logic        is_token_end;
  logic [7:0]  text_byte;
  logic [3:0]  token_kind;
  logic [15:0] line_number;
  logic        last_of_run;

  modport source (
    output valid, output is_token_end, output text_byte, output token_kind,
    output line_number, output last_of_run, input ready
  );
  modport sink (
    input valid, input is_token_end, input text_byte, input token_kind,
    input line_number, input last_of_run, output ready
  );
endinterface

>>> hw/rtl/config_text_tokenizer.sv
// Streaming tokenizer: one source byte (or the end marker) per request on src,
// token text bytes and token-end descriptors out on tokens. Each byte is
// classified in the cycle it is accepted, and all results it causes (at most
// five) are queued together in a four-entry queue; results leave one per
// cycle while tokens is ready, from the cycle after acceptance, and src
// stalls only when the queue fills. A byte that causes no result is not
// queued; plain text streams at one byte per cycle while tokens keeps up.
// last_of_run marks the final result of each request.
module config_text_tokenizer import ctt_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  ctt_in_if.sink    src,
  ctt_out_if.source tokens
);

  q_stat_t qstat;
  logic    push;
  entry_t  push_entry;
  logic    pop;
  entry_t  head;

  ctt_front u_front (
    .clk        (clk),
    .rst        (rst),
    .src        (src),
    .qstat      (qstat),
    .push       (push),
    .push_entry (push_entry)
  );

  ctt_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .stat       (qstat)
  );

  ctt_back u_back (
    .clk   (clk),
    .rst   (rst),
    .head  (head),
    .qstat (qstat),
    .pop   (pop),
    .dst   (tokens)
  );

endmodule

>>> hw/rtl/ctt_front.sv
module ctt_front import ctt_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  ctt_in_if.sink  src,
  input  q_stat_t qstat,
  output logic    push,
  output entry_t  push_entry
);

  mode_t                mode;
  mode_t                mode_next;
  logic [LINE_BITS-1:0] line;
  logic [LINE_BITS-1:0] line_next;
  logic [LINE_BITS-1:0] line_inc;

  step_t st [4];
  mode_t md [5];
  logic  live [5];
  logic  inc;
  run_t  acc;
  logic  accept;

  assign src.ready = !qstat.full;
  assign accept    = src.valid && src.ready;

  // up to four passes over the same byte, results appended in order
  always_comb begin
    md[0]   = mode;
    live[0] = 1'b1;
    acc     = '0;
    inc     = 1'b0;
    for (int i = 0; i < 4; i++) begin
      st[i] = feed(md[i], src.source_byte);
      if (live[i]) begin
        for (int j = 0; j < 3; j++) begin
          if (j < int'(st[i].n) && int'(acc.n) + j < RES_SLOTS) begin
            acc.r[CNT_W'(int'(acc.n) + j)] = st[i].r[j];
          end
        end
        acc.n     = acc.n + CNT_W'(st[i].n);
        inc       = inc | st[i].inc;
        md[i+1]   = st[i].mode;
        live[i+1] = !st[i].consumed;
      end else begin
        md[i+1]   = md[i];
        live[i+1] = 1'b0;
      end
    end
    if (src.end_marker) begin
      acc = flush(mode);
    end
  end

  assign line_inc = (inc && line != LINE_MAX) ? line + 1'b1 : line;

  always_comb begin
    mode_next = mode;
    line_next = line;
    if (accept) begin
      if (src.end_marker) begin
        mode_next = M_IDLE;
        line_next = LINE_BITS'(1);
      end else begin
        mode_next = md[4];
        line_next = line_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= M_IDLE;
      line <= LINE_BITS'(1);
    end else begin
      mode <= mode_next;
      line <= line_next;
    end
  end

  assign push                = accept && acc.n != '0;
  assign push_entry.res      = acc.r;
  assign push_entry.count    = acc.n;
  assign push_entry.line_old = line_clamp(line);
  assign push_entry.line_new = line_clamp(line_inc);

endmodule

>>> hw/rtl/ctt_queue.sv
`include "assert_macros.svh"

module ctt_queue import ctt_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  entry_t  push_entry,
  input  logic    pop,
  output entry_t  head,
  output q_stat_t stat
);

  entry_t               slots [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr;
  logic [Q_PTR_W-1:0]   rd_ptr;
  logic [Q_CNT_W-1:0]   count;

  assign stat.full  = count == Q_CNT_W'(Q_DEPTH);
  assign stat.empty = count == '0;
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `CTT_ASSERT_NEVER(a_push_full, push && stat.full, "queue written while full")
  `CTT_ASSERT_NEVER(a_pop_empty, pop && stat.empty, "queue read while empty")
  `CTT_ASSERT(a_count_range, count <= Q_CNT_W'(Q_DEPTH), "queue count out of range")

endmodule

>>> hw/rtl/ctt_back.sv
`include "assert_macros.svh"

module ctt_back import ctt_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  entry_t     head,
  input  q_stat_t    qstat,
  output logic       pop,
  ctt_out_if.source  dst
);

  logic [CNT_W-1:0] idx;
  logic [CNT_W-1:0] idx_next;
  res_t             cur;
  logic             last;
  logic             take;

  assign cur  = head.res[idx];
  assign last = idx == head.count - 1'b1;
  assign take = dst.valid && dst.ready;
  assign pop  = take && last;

  assign dst.valid        = !qstat.empty;
  assign dst.is_token_end = cur.is_end;
  assign dst.text_byte    = cur.text;
  assign dst.token_kind   = cur.kind;
  assign dst.line_number  = cur.bumped ? head.line_new : head.line_old;
  assign dst.last_of_run  = last;

  always_comb begin
    idx_next = idx;
    if (take) begin
      idx_next = last ? '0 : idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else begin
      idx <= idx_next;
    end
  end

  `CTT_ASSERT(a_head_count, !qstat.empty |-> (head.count != '0 && head.count <= CNT_W'(RES_SLOTS)), "empty run queued")
  `CTT_ASSERT(a_idx_range, !qstat.empty |-> idx < head.count, "result index past run")
  `CTT_ASSERT(a_idx_hold, (dst.valid && !dst.ready) |=> $stable(idx), "index moved under stall")

endmodule

>>> test/config_text_tokenizer_tb.sv
module config_text_tokenizer_tb;
  import ctt_pkg::*;

  localparam int MAX_GAP      = 20;
  localparam int MAX_STALL    = 20;
  localparam int HOLD_AT      = 50;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 20;
  localparam int GEN_ITEMS    = 90;
  localparam int MAX_RES      = 8;

  typedef struct packed {
    logic       is_end;
    logic [7:0] text;
    logic [3:0] kind;
    logic [15:0] line;
    logic       last;
  } tok_res_t;

  typedef struct packed {
    logic       eom;
    logic [7:0] ch;
  } src_item_t;

  logic clk;
  logic rst;

  ctt_in_if  src_bus ();
  ctt_out_if tok_bus ();

  config_text_tokenizer dut (
    .clk    (clk),
    .rst    (rst),
    .src    (src_bus),
    .tokens (tok_bus)
  );

  src_item_t pending[$];
  tok_res_t  token_q[$];
  tok_res_t  burst[$];

  mode_t       scan_md;
  int unsigned line_no;
  longint      line_top = (longint'(1) << LINE_BITS) - 1;

  int     n_items;
  int     taken_cnt;
  int     fail_cnt;
  int     hold_left;
  bit     hold_used;
  longint cycle_cnt;
  longint cycle_limit;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit digit_ch(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit alpha_ch(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit punct_ch(logic [7:0] c, output kind_t k);
    k = K_ERROR;
    case (c)
      CH_COLON:    k = K_COLON;
      CH_COMMA:    k = K_COMMA;
      CH_LBRACKET: k = K_LBRACKET;
      CH_RBRACKET: k = K_RBRACKET;
      CH_LBRACE:   k = K_LBRACE;
      CH_RBRACE:   k = K_RBRACE;
      default:     return 1'b0;
    endcase
    return 1'b1;
  endfunction

  function automatic void put_res(logic is_end, logic [7:0] b, kind_t k);
    tok_res_t r;
    if (burst.size() >= MAX_RES) return;
    r.is_end = is_end;
    r.text   = is_end ? 8'h00 : b;
    r.kind   = is_end ? k : K_IDENT;
    r.line   = line_no > 32'hFFFF ? 16'hFFFF : 16'(line_no);
    r.last   = 1'b0;
    burst = {burst, r};
  endfunction

  function automatic void put_text(logic [7:0] b);
    put_res(1'b0, b, K_IDENT);
  endfunction

  function automatic void put_end(kind_t k);
    put_res(1'b1, 8'h00, k);
  endfunction

  // one scanner pass; 0 means the byte must be seen again in the new mode
  function automatic bit scan_pass(logic [7:0] c);
    kind_t pk;
    case (scan_md)
      M_IDLE: begin
        if (c == CH_SPACE || c == CH_TAB || c == CH_CR) return 1'b1;
        if (c == CH_LF) begin
          if (line_no < line_top) line_no++;
          put_text(c);
          put_end(K_NEWLINE);
          return 1'b1;
        end
        if (c == CH_HASH) begin
          scan_md = M_COMMENT;
          return 1'b1;
        end
        if (punct_ch(c, pk)) begin
          put_text(c);
          put_end(pk);
          return 1'b1;
        end
        if (c == CH_LT) begin
          scan_md = M_KEY;
        end else if (c == CH_QUOTE) begin
          scan_md = M_STR;
        end else if (c == CH_DOT) begin
          scan_md = M_DOT;
        end else if (c == CH_MINUS) begin
          scan_md = M_MINUS;
        end else if (alpha_ch(c) || c == CH_UNDERSCORE) begin
          put_text(c);
          scan_md = M_IDENT;
        end else if (digit_ch(c)) begin
          put_text(c);
          scan_md = M_INT;
        end else begin
          put_text(c);
          put_end(K_ERROR);
        end
        return 1'b1;
      end
      M_COMMENT: begin
        if (c == CH_LF) begin
          scan_md = M_IDLE;
          return 1'b0;
        end
        return 1'b1;
      end
      M_IDENT: begin
        if (alpha_ch(c) || digit_ch(c) || c == CH_UNDERSCORE) begin
          put_text(c);
          return 1'b1;
        end
        put_end(K_IDENT);
        scan_md = M_IDLE;
        return 1'b0;
      end
      M_MINUS: begin
        put_text(CH_MINUS);
        if (digit_ch(c)) begin
          put_text(c);
          scan_md = M_INT;
          return 1'b1;
        end
        put_end(K_ERROR);
        scan_md = M_IDLE;
        return 1'b0;
      end
      M_INT: begin
        if (digit_ch(c)) begin
          put_text(c);
          return 1'b1;
        end
        if (c == CH_DOT) begin
          scan_md = M_INTDOT;
          return 1'b1;
        end
        if (c == CH_LOWER_E || c == CH_UPPER_E) begin
          put_text(c);
          scan_md = M_EXP;
          return 1'b1;
        end
        put_end(K_INT);
        scan_md = M_IDLE;
        return 1'b0;
      end
      M_INTDOT: begin
        if (digit_ch(c)) begin
          put_text(CH_DOT);
          put_text(c);
          scan_md = M_FRAC;
          return 1'b1;
        end
        put_end(K_INT);
        scan_md = M_DOT;
        return 1'b0;
      end
      M_FRAC: begin
        if (digit_ch(c)) begin
          put_text(c);
          return 1'b1;
        end
        if (c == CH_LOWER_E || c == CH_UPPER_E) begin
          put_text(c);
          scan_md = M_EXP;
          return 1'b1;
        end
        put_end(K_FLOAT);
        scan_md = M_IDLE;
        return 1'b0;
      end
      M_EXP: begin
        if (c == CH_PLUS || c == CH_MINUS || digit_ch(c)) begin
          put_text(c);
          scan_md = M_EXPDIG;
          return 1'b1;
        end
        put_end(K_FLOAT);
        scan_md = M_IDLE;
        return 1'b0;
      end
      M_EXPDIG: begin
        if (digit_ch(c)) begin
          put_text(c);
          return 1'b1;
        end
        put_end(K_FLOAT);
        scan_md = M_IDLE;
        return 1'b0;
      end
      M_DOT: begin
        scan_md = M_IDLE;
        put_text(CH_DOT);
        if (c == CH_DOT) begin
          put_text(CH_DOT);
          put_end(K_DOTDOT);
          return 1'b1;
        end
        put_end(K_ERROR);
        return 1'b0;
      end
      M_STR: begin
        if (c == CH_QUOTE) begin
          put_end(K_STRING);
          scan_md = M_IDLE;
          return 1'b1;
        end
        if (c == CH_LF) begin
          put_end(K_STRING);
          scan_md = M_IDLE;
          return 1'b0;
        end
        if (c == CH_BSLASH) scan_md = M_STRESC;
        else put_text(c);
        return 1'b1;
      end
      M_STRESC: begin
        scan_md = M_STR;
        if (c == CH_LOWER_N) begin
          put_text(CH_LF);
        end else if (c == CH_LOWER_T) begin
          put_text(CH_TAB);
        end else if (c == CH_QUOTE || c == CH_BSLASH) begin
          put_text(c);
        end else begin
          put_text(CH_BSLASH);
          put_text(c);
        end
        return 1'b1;
      end
      M_KEY: begin
        if (c == CH_GT) begin
          put_end(K_KEYBIND);
          scan_md = M_IDLE;
          return 1'b1;
        end
        if (c == CH_LF) begin
          put_end(K_KEYBIND);
          scan_md = M_IDLE;
          return 1'b0;
        end
        if (c == CH_BSLASH) scan_md = M_KEYESC;
        else put_text(c);
        return 1'b1;
      end
      M_KEYESC: begin
        put_text(CH_BSLASH);
        put_text(c);
        scan_md = M_KEY;
        return 1'b1;
      end
      default: begin
        scan_md = M_IDLE;
        return 1'b0;
      end
    endcase
  endfunction

  function automatic void close_open_token();
    case (scan_md)
      M_IDENT: put_end(K_IDENT);
      M_MINUS: begin
        put_text(CH_MINUS);
        put_end(K_ERROR);
      end
      M_INT: put_end(K_INT);
      M_INTDOT: begin
        put_end(K_INT);
        put_text(CH_DOT);
        put_end(K_ERROR);
      end
      M_FRAC, M_EXP, M_EXPDIG: put_end(K_FLOAT);
      M_DOT: begin
        put_text(CH_DOT);
        put_end(K_ERROR);
      end
      M_STR: put_end(K_STRING);
      M_STRESC: begin
        put_text(CH_BSLASH);
        put_end(K_STRING);
      end
      M_KEY: put_end(K_KEYBIND);
      M_KEYESC: begin
        put_text(CH_BSLASH);
        put_end(K_KEYBIND);
      end
      default: ;
    endcase
    put_end(K_END);
  endfunction

  function automatic void predict_tokens(logic eom, logic [7:0] c);
    tok_res_t r;
    burst.delete();
    if (eom) begin
      close_open_token();
      scan_md = M_IDLE;
      line_no = 1;
    end else begin
      for (int i = 0; i < 4; i++) begin
        if (scan_pass(c)) break;
      end
    end
    foreach (burst[i]) begin
      r = burst[i];
      r.last = (i == burst.size() - 1);
      token_q = {token_q, r};
    end
  endfunction

  function automatic void push_byte(logic [7:0] b);
    src_item_t it;
    it.eom = 1'b0;
    it.ch  = b;
    pending = {pending, it};
    n_items++;
  endfunction

  function automatic void push_eom();
    src_item_t it;
    it.eom = 1'b1;
    it.ch  = 8'($urandom_range(0, 255));
    pending = {pending, it};
    n_items++;
  endfunction

  function automatic void push_str(string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endfunction

  function automatic logic [7:0] pick_digit();
    return 8'("0" + $urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] pick_alpha();
    return $urandom_range(0, 1) ? 8'("a" + $urandom_range(0, 25))
                                : 8'("A" + $urandom_range(0, 25));
  endfunction

  function automatic logic [7:0] pick_printable();
    return 8'($urandom_range(32, 126));
  endfunction

  // mostly well-formed tokens with random content, some noise
  task automatic gen_token();
    int r;
    int n;
    logic [7:0] b;
    r = $urandom_range(0, 99);
    if (r < 14) begin
      push_byte($urandom_range(0, 5) == 0 ? CH_UNDERSCORE : pick_alpha());
      repeat ($urandom_range(0, 5)) begin
        n = $urandom_range(0, 5);
        push_byte(n == 0 ? CH_UNDERSCORE : n < 3 ? pick_digit() : pick_alpha());
      end
    end else if (r < 26) begin
      if ($urandom_range(0, 2) == 0) push_byte(CH_MINUS);
      repeat ($urandom_range(1, 4)) push_byte(pick_digit());
      if ($urandom_range(0, 9) == 0) push_byte(CH_DOT);
    end else if (r < 36) begin
      if ($urandom_range(0, 3) == 0) push_byte(CH_MINUS);
      repeat ($urandom_range(1, 3)) push_byte(pick_digit());
      push_byte(CH_DOT);
      repeat ($urandom_range(1, 3)) push_byte(pick_digit());
      if ($urandom_range(0, 1)) begin
        push_byte($urandom_range(0, 1) ? CH_LOWER_E : CH_UPPER_E);
        n = $urandom_range(0, 2);
        if (n == 1) push_byte(CH_PLUS);
        else if (n == 2) push_byte(CH_MINUS);
        repeat ($urandom_range(0, 2)) push_byte(pick_digit());
      end
    end else if (r < 46) begin
      push_byte(CH_QUOTE);
      repeat ($urandom_range(0, 6)) begin
        if ($urandom_range(0, 3) == 0) begin
          push_byte(CH_BSLASH);
          n = $urandom_range(0, 5);
          push_byte(n == 0 ? CH_LOWER_N : n == 1 ? CH_LOWER_T : n == 2 ? CH_QUOTE :
                    n == 3 ? CH_BSLASH : n == 4 ? CH_LF : pick_printable());
        end else begin
          push_byte(pick_printable());
        end
      end
      if ($urandom_range(0, 4) != 0) push_byte(CH_QUOTE);
    end else if (r < 54) begin
      push_byte(CH_LT);
      repeat ($urandom_range(0, 5)) begin
        if ($urandom_range(0, 3) == 0) begin
          push_byte(CH_BSLASH);
          push_byte(8'($urandom_range(0, 255)));
        end else begin
          push_byte(pick_printable());
        end
      end
      if ($urandom_range(0, 6) != 0) push_byte(CH_GT);
    end else if (r < 66) begin
      case ($urandom_range(0, 6))
        0: push_byte(CH_COLON);
        1: push_byte(CH_COMMA);
        2: push_byte(CH_LBRACKET);
        3: push_byte(CH_RBRACKET);
        4: push_byte(CH_LBRACE);
        5: push_byte(CH_RBRACE);
        default: push_str("..");
      endcase
    end else if (r < 74) begin
      push_byte(CH_LF);
    end else if (r < 80) begin
      n = $urandom_range(0, 2);
      push_byte(n == 0 ? CH_SPACE : n == 1 ? CH_TAB : CH_CR);
    end else if (r < 85) begin
      push_byte(CH_HASH);
      repeat ($urandom_range(0, 4)) begin
        b = 8'($urandom_range(0, 255));
        push_byte(b == CH_LF ? CH_SPACE : b);
      end
      push_byte(CH_LF);
    end else if (r < 95) begin
      push_byte(8'($urandom_range(0, 255)));
    end else begin
      push_eom();
    end
    if ($urandom_range(0, 1)) push_byte(CH_SPACE);
  endtask

  task automatic report(string field, logic [31:0] got, logic [31:0] want);
    fail_cnt++;
    if (fail_cnt <= 50)
      $display("%0t mismatch %s: got %0h, expected %0h", $time, field, got, want);
  endtask

  task automatic check_token();
    tok_res_t w;
    if (token_q.size() == 0) begin
      report("token result with none pending",
             32'({tok_bus.is_token_end, tok_bus.token_kind, tok_bus.text_byte}), 32'h0);
      return;
    end
    w = token_q.pop_front();
    if (tok_bus.is_token_end !== w.is_end)
      report("is_token_end", 32'(tok_bus.is_token_end), 32'(w.is_end));
    if (tok_bus.text_byte !== w.text)
      report("text_byte", 32'(tok_bus.text_byte), 32'(w.text));
    if (tok_bus.token_kind !== w.kind)
      report("token_kind", 32'(tok_bus.token_kind), 32'(w.kind));
    if (tok_bus.line_number !== w.line)
      report("line_number", 32'(tok_bus.line_number), 32'(w.line));
    if (tok_bus.last_of_run !== w.last)
      report("last_of_run", 32'(tok_bus.last_of_run), 32'(w.last));
  endtask

  always @(posedge clk) begin : drive_src
    src_item_t it;
    int gap_left;
    int r;
    if (rst) begin
      src_bus.valid <= 1'b0;
      gap_left = 0;
      scan_md = M_IDLE;
      line_no = 1;
    end else begin
      if (src_bus.valid && src_bus.ready) begin
        predict_tokens(src_bus.end_marker, src_bus.source_byte);
        taken_cnt <= taken_cnt + 1;
      end
      if (!src_bus.valid || src_bus.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          src_bus.valid <= 1'b0;
        end else if (pending.size() > 0) begin
          it = pending.pop_front();
          src_bus.valid       <= 1'b1;
          src_bus.end_marker  <= it.eom;
          src_bus.source_byte <= it.ch;
          if ((taken_cnt / 40) % 4 == 1) begin
            gap_left = 0;
          end else begin
            r = $urandom_range(0, 99);
            gap_left = r < 70 ? 0 : r < 95 ? $urandom_range(1, 3) : $urandom_range(5, MAX_GAP);
          end
        end else begin
          src_bus.valid <= 1'b0;
        end
      end
    end
  end

  // one long receiver hold-off so the block's queue fills and src stalls
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_used <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_used && taken_cnt >= HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_used <= 1'b1;
    end
  end

  always @(posedge clk) begin : watch_tokens
    int stall_left;
    int r;
    if (rst) begin
      tok_bus.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (tok_bus.valid && tok_bus.ready) check_token();
      if (hold_left != 0) begin
        tok_bus.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        tok_bus.ready <= 1'b0;
      end else if ((cycle_cnt / 300) % 4 == 2) begin
        tok_bus.ready <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 75) begin
          tok_bus.ready <= 1'b1;
        end else begin
          tok_bus.ready <= 1'b0;
          stall_left = r < 95 ? $urandom_range(0, 2) : $urandom_range(4, MAX_STALL - 1);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_limit > 0 && cycle_cnt >= cycle_limit) begin
      $display("config_text_tokenizer test failed");
      $finish;
    end
  end

  initial begin
    int start;
    rst = 1'b1;
    src_bus.valid = 1'b0;
    src_bus.source_byte = 8'h00;
    src_bus.end_marker = 1'b0;
    tok_bus.ready = 1'b0;
    cycle_cnt = 0;
    cycle_limit = 0;

    // byte extremes, lone minus and dot, digits then two dots
    push_byte(8'h00);
    push_byte(8'hFF);
    push_str("-,.:1..");
    push_str("a[]{}");
    // unknown escape, escaped newline kept in string, newline closes string
    push_str("\"\\q\\\n\n");
    push_str("#\n");
    // float cut by keybind, keybind left open with dangling backslash
    push_str("3.5E<\\");
    push_eom();

    start = n_items;
    while (n_items - start < GEN_ITEMS) gen_token();

    push_str("k:");
    push_eom();
    push_str("z");
    push_eom();

    cycle_limit = 3 * (longint'(n_items) * (MAX_GAP + 1)
                  + longint'(n_items) * MAX_RES * (MAX_STALL + 1))
                  + HOLD_CYCLES + 2000;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    while (taken_cnt != n_items) @(posedge clk);
    while (token_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_cnt == 0) begin
      $display("config_text_tokenizer test passed");
    end else begin
      $display("config_text_tokenizer test failed");
    end
    $finish;
  end

endmodule
